// ===== rtl/ryuv_pkg.sv =====
// Package: shared types and constants for the RGB to YCbCr 4:2:0 converter.
package ryuv_pkg;

    localparam int MAX_DIMENSION = 4096;
    localparam int DIM_W         = $clog2(MAX_DIMENSION) + 1;   // register width
    localparam int CNT_W         = $clog2(MAX_DIMENSION);       // position counter width

    // Configuration register indexes
    localparam logic [1:0] CFG_COLOR_ORDER  = 2'd0;
    localparam logic [1:0] CFG_FRAME_WIDTH  = 2'd1;
    localparam logic [1:0] CFG_FRAME_HEIGHT = 2'd2;

    // Byte order codes
    localparam logic [1:0] ORDER_BGR  = 2'd0;
    localparam logic [1:0] ORDER_XRGB = 2'd1;
    localparam logic [1:0] ORDER_RGB  = 2'd2;

    localparam logic [1:0]       RESET_COLOR_ORDER  = ORDER_BGR;
    localparam logic [DIM_W-1:0] RESET_FRAME_WIDTH  = DIM_W'(640);
    localparam logic [DIM_W-1:0] RESET_FRAME_HEIGHT = DIM_W'(480);

    localparam logic [7:0] LUMA_BIAS   = 8'd16;
    localparam logic [7:0] CHROMA_BIAS = 8'd128;

    typedef struct packed {
        logic [7:0] byte_zero;
        logic [7:0] byte_one;
        logic [7:0] byte_two;
        logic [7:0] byte_three;
    } t_pixel_in;

    typedef struct packed {
        logic [7:0] luma;
        logic       chroma_present;
        logic [7:0] blue_diff;
        logic [7:0] red_diff;
        logic       end_of_frame;
    } t_pixel_out;

endpackage

// ===== rtl/rgb_to_yuv420_subsample.sv =====
// Top level: BT.601 RGB to YCbCr converter with 4:2:0 chroma sampling.
//
// Input channel: i_in_valid / o_in_stall carry one raw pixel (four bytes) per
// transfer. Output channel: o_out_valid / i_out_stall carry one result per
// pixel: luma, and on even rows and columns of the even-sized frame area also
// Cb/Cr with chroma_present set; end_of_frame marks the last pixel.
// Configuration: i_cfg_we writes i_cfg_data into register i_cfg_index
// (0 byte order, 1 frame width, 2 frame height); write only while idle.
//
// Pipeline: an accepted pixel passes through two register stages (byte select
// and position flags, then the constant-coefficient sums) to the output.
// Throughput: one pixel per cycle while the receiver does not stall.
//
// Reset clears both stages, the raster position and restores the registers
// to byte order 0, 640 by 480. When the receiver stalls, the output holds
// and the stages behind it fill; o_in_stall rises once both stages are full.
module rgb_to_yuv420_subsample (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  ryuv_pkg::t_pixel_in          i_pixel,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output ryuv_pkg::t_pixel_out         o_result,
    input  logic                         i_cfg_we,
    input  logic [1:0]                   i_cfg_index,
    input  logic [ryuv_pkg::DIM_W-1:0]   i_cfg_data
);

    localparam int DW = ryuv_pkg::DIM_W;
    localparam int CW = ryuv_pkg::CNT_W;

    // Configuration registers
    logic [1:0]    r_color_order;
    logic [DW-1:0] r_frame_width;
    logic [DW-1:0] r_frame_height;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_color_order  <= ryuv_pkg::RESET_COLOR_ORDER;
            r_frame_width  <= ryuv_pkg::RESET_FRAME_WIDTH;
            r_frame_height <= ryuv_pkg::RESET_FRAME_HEIGHT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ryuv_pkg::CFG_COLOR_ORDER:  r_color_order  <= i_cfg_data[1:0];
                ryuv_pkg::CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data;
                ryuv_pkg::CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp dimensions to 1..MAX_DIMENSION
    logic [DW-1:0] w_eff, h_eff, w_last, h_last;

    always_comb begin
        if (r_frame_width == '0)
            w_eff = DW'(1);
        else if (r_frame_width > DW'(ryuv_pkg::MAX_DIMENSION))
            w_eff = DW'(ryuv_pkg::MAX_DIMENSION);
        else
            w_eff = r_frame_width;
        if (r_frame_height == '0)
            h_eff = DW'(1);
        else if (r_frame_height > DW'(ryuv_pkg::MAX_DIMENSION))
            h_eff = DW'(ryuv_pkg::MAX_DIMENSION);
        else
            h_eff = r_frame_height;
        w_last = w_eff - DW'(1);
        h_last = h_eff - DW'(1);
    end

    // Handshake: a stage advances when it is empty or the one ahead moves
    logic r_s1_valid, r_out_valid;
    logic out_en, s1_en, in_xfer;

    assign out_en     = !r_out_valid || !i_out_stall;
    assign s1_en      = !r_s1_valid || out_en;
    assign o_in_stall = !s1_en;
    assign in_xfer    = i_in_valid && s1_en;

    // Raster position of the next pixel
    logic [CW-1:0] r_column, r_row;
    logic          row_end, frame_end, chroma;

    always_comb begin
        row_end   = {1'b0, r_column} >= w_last;
        frame_end = row_end && ({1'b0, r_row} >= h_last);
        chroma    = !r_column[0] && !r_row[0]
                    && ({1'b0, r_column} < {w_eff[DW-1:1], 1'b0})
                    && ({1'b0, r_row} < {h_eff[DW-1:1], 1'b0});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            r_row    <= '0;
        end else if (in_xfer) begin
            if (frame_end) begin
                r_column <= '0;
                r_row    <= '0;
            end else if (row_end) begin
                r_column <= '0;
                r_row    <= r_row + CW'(1);
            end else begin
                r_column <= r_column + CW'(1);
            end
        end
    end

    // Stage 1: byte selection and position flags
    logic [7:0] n_red, n_green, n_blue;
    logic [7:0] r_red, r_green, r_blue;
    logic       r_s1_chroma, r_s1_eof;

    always_comb begin
        unique case (r_color_order)
            ryuv_pkg::ORDER_BGR: begin
                n_blue  = i_pixel.byte_zero;
                n_green = i_pixel.byte_one;
                n_red   = i_pixel.byte_two;
            end
            ryuv_pkg::ORDER_XRGB: begin
                n_red   = i_pixel.byte_one;
                n_green = i_pixel.byte_two;
                n_blue  = i_pixel.byte_three;
            end
            default: begin
                n_red   = i_pixel.byte_zero;
                n_green = i_pixel.byte_one;
                n_blue  = i_pixel.byte_two;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_s1_valid <= 1'b0;
        else if (s1_en)
            r_s1_valid <= i_in_valid;
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_red       <= n_red;
            r_green     <= n_green;
            r_blue      <= n_blue;
            r_s1_chroma <= chroma;
            r_s1_eof    <= frame_end;
        end
    end

    // Stage 2: constant-coefficient sums, floor shift, bias
    logic signed [17:0] sr, sg, sb;
    logic signed [17:0] y_sum, cb_sum, cr_sum;
    logic [7:0]         y_val, cb_val, cr_val;
    ryuv_pkg::t_pixel_out n_result, r_result;

    always_comb begin
        sr = $signed({10'd0, r_red});
        sg = $signed({10'd0, r_green});
        sb = $signed({10'd0, r_blue});
        y_sum  = 18'sd66 * sr + 18'sd129 * sg + 18'sd25 * sb + 18'sd128;
        cb_sum = 18'sd112 * sb - 18'sd38 * sr - 18'sd74 * sg + 18'sd128;
        cr_sum = 18'sd112 * sr - 18'sd94 * sg - 18'sd18 * sb + 18'sd128;
        // arithmetic shift by 8 is floor division; keep the low byte
        y_val  = y_sum[15:8] + ryuv_pkg::LUMA_BIAS;
        cb_val = cb_sum[15:8] + ryuv_pkg::CHROMA_BIAS;
        cr_val = cr_sum[15:8] + ryuv_pkg::CHROMA_BIAS;
        n_result.luma           = y_val;
        n_result.chroma_present = r_s1_chroma;
        n_result.blue_diff      = r_s1_chroma ? cb_val : 8'd0;
        n_result.red_diff       = r_s1_chroma ? cr_val : 8'd0;
        n_result.end_of_frame   = r_s1_eof;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n)
            r_out_valid <= 1'b0;
        else if (out_en)
            r_out_valid <= r_s1_valid;
    end

    always_ff @(posedge i_clk) begin
        if (out_en && r_s1_valid)
            r_result <= n_result;
    end

    assign o_out_valid = r_out_valid;
    assign o_result    = r_result;

endmodule
